@@ rtl/core/psrl_pkg.sv @@
// Shared types and constants for the per-source fixed-window rate limiter.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package psrl_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgWindowMs    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxRequests = 2'd1;

  localparam logic [TimeW-1:0]  WindowMsRst    = 32'd60000;
  localparam logic [CountW-1:0] MaxRequestsRst = 8'd5;

  // One entry of the slot table
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [TimeW-1:0]  start;
    logic [CountW-1:0] count;
  } slot_t;

endpackage

@@ rtl/core/psrl_if.sv @@
// Valid/ready channel interfaces: request (address, timestamp) and response.
// Depends on psrl_pkg for field widths.
`timescale 1ns / 1ps

interface psrl_req_if;
  logic                         valid;
  logic                         ready;
  logic [psrl_pkg::AddrW-1:0]   source_addr;
  logic [psrl_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, output source_addr, output now_ms, input ready);
  modport sink   (input valid, input source_addr, input now_ms, output ready);
endinterface

interface psrl_rsp_if;
  logic valid;
  logic ready;
  logic allowed;

  modport source (output valid, output allowed, input ready);
  modport sink   (input valid, input allowed, output ready);
endinterface

@@ rtl/core/per_source_fixed_window_rate_limiter_unit.sv @@
// Per-source fixed-window rate limiter, top level: scan sequencer and result register.
// Depends on psrl_pkg, psrl_if, psrl_slot_ram and psrl_cfg_regs.
//
//   channel   dir  handshake            payload
//   req_i     in   valid/ready          source_addr[31:0], now_ms[31:0]
//   rsp_o     out  valid/ready          allowed
//   cfg       in   cfg_we_i (no stall)  cfg_idx_i[1:0], cfg_wdata_i[31:0]
//
// After accept, the scan reads the table entries in order on the slot RAM read port
// (a match ends the scan early); then an update state writes the entry back and the
// result state loads the output register.
// A new request is accepted once the previous result sits in the output register.
// A full output register stalls the sequencer in its result state.
// Reset clears the per-slot used bits at once; no clearing pass is needed.
`timescale 1ns / 1ps

module per_source_fixed_window_rate_limiter_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  psrl_req_if.sink                        req_i,
  psrl_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [psrl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [psrl_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StUpdate = 4'b0100,
    StResp   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [psrl_pkg::TimeW-1:0]  window_ms;
  logic [psrl_pkg::CountW-1:0] max_requests;

  psrl_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .window_ms_o    (window_ms),
    .max_requests_o (max_requests)
  );

  // Slot table
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  psrl_pkg::slot_t ram_wdata, ram_rdata;

  psrl_slot_ram #(.Depth(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [SLOTS-1:0] used_q;

  // Request and scan bookkeeping
  logic [psrl_pkg::AddrW-1:0]  addr_q;
  logic [psrl_pkg::TimeW-1:0]  now_q;
  logic [IdxW-1:0]             idx_q;
  logic                        hit_q;
  logic [IdxW-1:0]             hit_idx_q;
  logic [psrl_pkg::TimeW-1:0]  hit_start_q;
  logic [psrl_pkg::CountW-1:0] hit_count_q;
  logic                        have_free_q;
  logic [IdxW-1:0]             free_idx_q;
  logic [IdxW-1:0]             victim_idx_q;
  logic [psrl_pkg::TimeW-1:0]  victim_start_q;
  logic                        res_q;
  logic                        rsp_valid_q;
  logic                        rsp_allowed_q;

  logic req_fire, rsp_load, entry_used, entry_match, scan_last;
  logic [psrl_pkg::TimeW-1:0] age;
  logic                       expired, at_limit;
  logic [IdxW-1:0]            pick_idx;

  assign req_fire    = req_i.valid & req_i.ready;
  assign entry_used  = used_q[idx_q];
  assign entry_match = entry_used && (ram_rdata.addr == addr_q);
  assign scan_last   = (idx_q == LastIdx);
  assign rsp_load    = (state_q == StResp) && (!rsp_valid_q || rsp_o.ready);

  // Decision terms for a matched entry, and the slot to write
  assign age      = now_q - hit_start_q;
  assign expired  = age > window_ms;
  assign at_limit = hit_count_q >= max_requests;
  assign pick_idx = hit_q ? hit_idx_q : (have_free_q ? free_idx_q : victim_idx_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (req_fire) state_d = StScan;
      StScan:   if (entry_match || scan_last) state_d = StUpdate;
      StUpdate: state_d = StResp;
      StResp:   if (rsp_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Read entry 0 on accept, then the next entry each scan cycle
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_q == StIdle) begin
      ram_re = req_fire;
    end else if (state_q == StScan) begin
      ram_re    = !scan_last;
      ram_raddr = idx_q + 1'b1;
    end
  end

  // Write back: window restart, count increment or fresh claim; a denial writes nothing
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = pick_idx;
    ram_wdata.addr  = addr_q;
    ram_wdata.start = now_q;
    ram_wdata.count = psrl_pkg::CountW'(1);
    if (state_q == StUpdate) begin
      if (!hit_q || expired) begin
        ram_we = 1'b1;
      end else if (!at_limit) begin
        ram_we          = 1'b1;
        ram_wdata.start = hit_start_q;
        ram_wdata.count = hit_count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StUpdate && !hit_q) begin
        used_q[pick_idx] <= 1'b1;
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      addr_q         <= req_i.source_addr;
      now_q          <= req_i.now_ms;
      idx_q          <= '0;
      hit_q          <= 1'b0;
      have_free_q    <= 1'b0;
      free_idx_q     <= '0;
      victim_idx_q   <= '0;
      victim_start_q <= '1;
    end else if (state_q == StScan) begin
      idx_q <= idx_q + 1'b1;
      if (entry_match) begin
        hit_q       <= 1'b1;
        hit_idx_q   <= idx_q;
        hit_start_q <= ram_rdata.start;
        hit_count_q <= ram_rdata.count;
      end else if (!entry_used) begin
        if (!have_free_q) begin
          have_free_q <= 1'b1;
          free_idx_q  <= idx_q;
        end
      end else if (ram_rdata.start < victim_start_q) begin
        victim_idx_q   <= idx_q;
        victim_start_q <= ram_rdata.start;
      end
    end
    if (state_q == StUpdate) begin
      res_q <= !hit_q || expired || !at_limit;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_allowed_q <= res_q;
    end
  end

  assign req_i.ready   = (state_q == StIdle);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.allowed = rsp_allowed_q;

endmodule

@@ rtl/core/psrl_slot_ram.sv @@
// Slot table storage: one write port, one read port, registered read data.
// Depends on psrl_pkg for the entry type.
`timescale 1ns / 1ps

module psrl_slot_ram #(
  parameter int unsigned Depth = 8,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  psrl_pkg::slot_t     wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output psrl_pkg::slot_t     rdata_o
);

  psrl_pkg::slot_t mem [Depth];
  psrl_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/psrl_cfg_regs.sv @@
// Configuration registers: window length and per-window request limit.
// Depends on psrl_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module psrl_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psrl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [psrl_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic [psrl_pkg::TimeW-1:0]      window_ms_o,
  output logic [psrl_pkg::CountW-1:0]     max_requests_o
);

  logic [psrl_pkg::TimeW-1:0]  window_ms_q;
  logic [psrl_pkg::CountW-1:0] max_requests_q;

  // Writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms_q    <= psrl_pkg::WindowMsRst;
      max_requests_q <= psrl_pkg::MaxRequestsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psrl_pkg::CfgWindowMs: begin
          window_ms_q <= cfg_wdata_i[psrl_pkg::TimeW-1:0];
        end
        psrl_pkg::CfgMaxRequests: begin
          max_requests_q <= cfg_wdata_i[psrl_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign window_ms_o    = window_ms_q;
  assign max_requests_o = max_requests_q;

endmodule
